### rtl/click_detect_slew_repair_core_macros.svh
// Assertion macros for the click detect / slew repair core.
`ifndef CLICK_DETECT_SLEW_REPAIR_CORE_MACROS_SVH
`define CLICK_DETECT_SLEW_REPAIR_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CDSR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CDSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/cdsr_pkg.sv
// Constants shared by the click detect / slew repair core.
package cdsr_pkg;

  // Parameter defaults
  localparam int unsigned DEF_CHANNELS       = 2;
  localparam int unsigned DEF_SAMPLE_BITS    = 24;
  localparam int unsigned DEF_LOG_TABLE_BITS = 8;

  // Register indexes
  localparam logic [2:0] CFG_THRESHOLD = 3'd0;
  localparam logic [2:0] CFG_SMOOTHING = 3'd1;
  localparam logic [2:0] CFG_MIX       = 3'd2;
  localparam logic [2:0] CFG_RATE      = 3'd3;
  localparam logic [2:0] CFG_MOD_EN    = 3'd4;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 18;

  // Register widths and reset values
  localparam int unsigned THR_BITS   = 16;
  localparam int unsigned CENT_BITS  = 11;
  localparam int unsigned WET_BITS   = 16;
  localparam int unsigned RATE_BITS  = 18;
  localparam int unsigned MOD_BITS   = 3;

  localparam logic [THR_BITS-1:0]  THR_RESET  = 16'd6554;
  localparam logic [CENT_BITS-1:0] CENT_RESET = 11'd500;
  localparam logic [WET_BITS-1:0]  WET_RESET  = 16'd65535;
  localparam logic [RATE_BITS-1:0] RATE_RESET = 18'd48000;
  localparam logic [MOD_BITS-1:0]  MOD_RESET  = 3'd0;

  // mod_enable bit positions
  localparam int unsigned MOD_THR_BIT  = 0;
  localparam int unsigned MOD_CENT_BIT = 1;
  localparam int unsigned MOD_WET_BIT  = 2;

  // Arithmetic constants
  localparam int unsigned SLEW_COEF    = 6554;    // 0.1 in Q0.16
  localparam int unsigned THR_MIN_Q16  = 655;     // 0.01
  localparam int unsigned THR_SPAN_Q16 = 64881;   // 1.0 - 0.01
  localparam longint unsigned LOG2_200_Q16 = 500948;
  localparam longint unsigned EXP_C1 = 45602;
  localparam longint unsigned EXP_C2 = 14815;
  localparam longint unsigned EXP_C3 = 5116;

  // Hold counter
  localparam int unsigned HOLD_BITS = 12;
  localparam int unsigned HOLD_MAX  = 4095;

  // centims * rate / 100000 = ((prod >> 5) * RECIP) >> 36, exact for prod < 2^29
  localparam int unsigned HOLD_PROD_W   = CENT_BITS + RATE_BITS;
  localparam int unsigned DIV_PRE_SHIFT = 5;
  localparam int unsigned DIV_RECIP     = 21990233;
  localparam int unsigned DIV_RECIP_W   = 25;
  localparam int unsigned DIV_SHIFT     = 36;
  localparam int unsigned DIV_FULL_W    = HOLD_PROD_W - DIV_PRE_SHIFT + DIV_RECIP_W;
  localparam int unsigned HOLD_Q_W      = DIV_FULL_W - DIV_SHIFT;

endpackage

### rtl/click_detect_slew_repair_core.sv
// Click detect / slew repair core: per-channel state memory and sample datapath.
//
// Sequence: ST_DET, ST_DIV, ST_UPD, ST_MIX, ST_OUT; ST_OUT waits for a free output.
// Input: no new word is taken until the read-modify-write sequence over the
//   single-port channel state memory ends; a stalled output word delays it further.
// Reset: config registers return to defaults, all channel state reads as zero
//   through per-entry valid bits; no clearing pass, word accepted right after reset.
`include "click_detect_slew_repair_core_macros.svh"

module click_detect_slew_repair_core import cdsr_pkg::*; #(
  parameter int unsigned CHANNELS       = DEF_CHANNELS,
  parameter int unsigned SAMPLE_BITS    = DEF_SAMPLE_BITS,
  parameter int unsigned LOG_TABLE_BITS = DEF_LOG_TABLE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input words
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          channel_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  input  logic [THR_BITS-1:0]           threshold_cv_i,
  input  logic [15:0]                   smoothing_cv_i,
  input  logic [WET_BITS-1:0]           amount_cv_i,
  // output words
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          channel_out_o,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o,
  output logic                          click_detected_o,
  output logic                          repairing_o,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata_i
);

  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned EW    = 2 * SB + HOLD_BITS;   // {prev, slew, hold}
  localparam int unsigned TAB_N = 1 << LOG_TABLE_BITS;
  localparam longint unsigned TAB_DEN = TAB_N - 1;
  localparam int unsigned SP_W  = SB + 15;              // slew product
  localparam int unsigned MP_W  = SB + 18;              // mix product / sum
  localparam int unsigned CMP_W = SB + 17;              // click compare

  localparam logic signed [14:0] SLEW_C = 15'(SLEW_COEF);
  localparam logic signed [MP_W-1:0] SAT_MAX = MP_W'((64'd1 << (SB - 1)) - 64'd1);
  localparam logic signed [MP_W-1:0] SAT_MIN = -SAT_MAX - MP_W'(1);

  // Sequencer codes
  localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for a word, memory read on accept
  localparam logic [2:0] ST_DET  = 3'd1;  // click test, hold product, slew product
  localparam logic [2:0] ST_DIV  = 3'd2;  // hold samples by reciprocal multiply
  localparam logic [2:0] ST_UPD  = 3'd3;  // state update, memory write-back
  localparam logic [2:0] ST_MIX  = 3'd4;  // wet difference times mix
  localparam logic [2:0] ST_OUT  = 3'd5;  // round, saturate, load output register

  // ---------------------------------------------------------------------------
  // Smoothing log table: 0.1..20 ms in centims, built at elaboration.
  // ---------------------------------------------------------------------------
  logic [CENT_BITS-1:0] cent_tab [TAB_N];

  for (genvar k = 0; k < TAB_N; k++) begin : g_tab
    localparam longint unsigned E  = (64'(k) * LOG2_200_Q16 + TAB_DEN / 2) / TAB_DEN;
    localparam longint unsigned EI = (E >> 16) & 64'd15;
    localparam longint unsigned EF = E & 64'hFFFF;
    localparam longint unsigned P1 = (EXP_C3 * EF) >> 16;
    localparam longint unsigned P2 = ((P1 + EXP_C2) * EF) >> 16;
    localparam longint unsigned P3 = ((P2 + EXP_C1) * EF) >> 16;
    localparam longint unsigned PP = P3 + 64'd65536;
    localparam longint unsigned CC = (((64'd10 * PP) << EI) + 64'd32768) >> 16;
    assign cent_tab[k] = CENT_BITS'(CC);
  end

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [THR_BITS-1:0]  thr_reg_q;
  logic [CENT_BITS-1:0] cent_reg_q;
  logic [WET_BITS-1:0]  wet_reg_q;
  logic [RATE_BITS-1:0] rate_reg_q;
  logic [MOD_BITS-1:0]  mod_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_reg_q  <= THR_RESET;
      cent_reg_q <= CENT_RESET;
      wet_reg_q  <= WET_RESET;
      rate_reg_q <= RATE_RESET;
      mod_en_q   <= MOD_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_THRESHOLD: thr_reg_q  <= cfg_wdata_i[THR_BITS-1:0];
        CFG_SMOOTHING: cent_reg_q <= cfg_wdata_i[CENT_BITS-1:0];
        CFG_MIX:       wet_reg_q  <= cfg_wdata_i[WET_BITS-1:0];
        CFG_RATE:      rate_reg_q <= cfg_wdata_i[RATE_BITS-1:0];
        CFG_MOD_EN:    mod_en_q   <= cfg_wdata_i[MOD_BITS-1:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer and handshake
  // ---------------------------------------------------------------------------
  logic [2:0] step_q, step_d;
  logic       in_acc;
  logic       out_valid_q;
  logic       out_free;

  assign in_stall_o = (step_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    step_d = step_q;
    case (step_q)
      ST_IDLE: if (in_acc) step_d = ST_DET;
      ST_DET:  step_d = ST_DIV;
      ST_DIV:  step_d = ST_UPD;
      ST_UPD:  step_d = ST_MIX;
      ST_MIX:  step_d = ST_OUT;
      ST_OUT:  if (out_free) step_d = ST_IDLE;
      default: step_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Accept: capture the word, resolve the controls, read the channel entry.
  // Threshold CV maps to 0.01..1 in Q0.16.
  // ---------------------------------------------------------------------------
  logic [CH_W-1:0]      ch_in;
  logic [31:0]          thr_prod;
  logic [THR_BITS-1:0]  thr_in;
  logic [CENT_BITS-1:0] cent_in;
  logic [WET_BITS-1:0]  wet_in;

  // with one channel the channel bit is ignored, so every word maps to entry 0
  assign ch_in    = (CHANNELS > 1) ? CH_W'(channel_i) : '0;
  assign thr_prod = 32'(threshold_cv_i) * 32'(THR_SPAN_Q16);
  assign thr_in   = mod_en_q[MOD_THR_BIT] ? THR_BITS'(thr_prod[31:16] + 16'(THR_MIN_Q16))
                                          : thr_reg_q;
  assign cent_in  = mod_en_q[MOD_CENT_BIT]
                  ? cent_tab[smoothing_cv_i[15 -: LOG_TABLE_BITS]] : cent_reg_q;
  assign wet_in   = mod_en_q[MOD_WET_BIT] ? amount_cv_i : wet_reg_q;

  logic signed [SB-1:0] x_q;
  logic                 chbit_q;
  logic [CH_W-1:0]      ch_q;
  logic [THR_BITS-1:0]  thr_q;
  logic [CENT_BITS-1:0] cent_q;
  logic [WET_BITS-1:0]  wet_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q     <= sample_in_i;
      chbit_q <= channel_i;
      ch_q    <= ch_in;
      thr_q   <= thr_in;
      cent_q  <= cent_in;
      wet_q   <= wet_in;
    end
  end

  // ---------------------------------------------------------------------------
  // Channel state memory, one entry per channel. Valid bits make a never written
  // entry read as zero. Read on accept, written back in ST_UPD; the sequencer
  // takes no new word before the write-back, so no forwarding is needed.
  // ---------------------------------------------------------------------------
  logic [EW-1:0]       mem [CHANNELS];
  logic [EW-1:0]       rd_q;
  logic                rd_vld_q;
  logic [CHANNELS-1:0] ent_vld_q;
  logic                mem_we;
  logic [EW-1:0]       wr_data;

  assign mem_we = (step_q == ST_UPD);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[ch_q] <= wr_data;
    end
    if (in_acc) begin
      rd_q <= mem[ch_in];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (mem_we) ent_vld_q[ch_q] <= 1'b1;
      if (in_acc) rd_vld_q <= ent_vld_q[ch_in];
    end
  end

  // ---------------------------------------------------------------------------
  // ST_DET: click test, hold product, slew step product.
  // ---------------------------------------------------------------------------
  logic signed [SB-1:0]    prev_r, slew_r;
  logic [HOLD_BITS-1:0]    hold_r;
  logic signed [SB:0]      delta;
  logic [SB:0]             delta_abs;
  logic [CMP_W-1:0]        cmp_lhs, cmp_rhs;
  logic signed [SB:0]      slew_diff;
  logic signed [SP_W-1:0]  slew_prod_d;

  assign prev_r = rd_vld_q ? rd_q[EW-1 -: SB] : '0;
  assign slew_r = rd_vld_q ? rd_q[SB+HOLD_BITS-1 -: SB] : '0;
  assign hold_r = rd_vld_q ? rd_q[HOLD_BITS-1:0] : '0;

  assign delta     = (SB+1)'(x_q) - (SB+1)'(prev_r);
  assign delta_abs = delta[SB] ? (SB+1)'(-delta) : (SB+1)'(delta);
  // |jump| * 2^16 > thr * 2^(SB-1)
  assign cmp_lhs   = CMP_W'(delta_abs) << 16;
  assign cmp_rhs   = CMP_W'(thr_q) << (SB - 1);

  assign slew_diff   = (SB+1)'(x_q) - (SB+1)'(slew_r);
  assign slew_prod_d = SP_W'(slew_diff) * SP_W'(SLEW_C);

  logic                     click_q;
  logic [HOLD_PROD_W-1:0]   hprod_q;
  logic signed [SP_W-1:0]   slew_prod_q;
  logic signed [SB-1:0]     slew_old_q;
  logic [HOLD_BITS-1:0]     hold_old_q;

  always_ff @(posedge clk_i) begin
    if (step_q == ST_DET) begin
      click_q     <= (cmp_lhs > cmp_rhs);
      hprod_q     <= HOLD_PROD_W'(cent_q) * HOLD_PROD_W'(rate_reg_q);
      slew_prod_q <= slew_prod_d;
      slew_old_q  <= slew_r;
      hold_old_q  <= hold_r;
    end
  end

  // ---------------------------------------------------------------------------
  // ST_DIV: samples = centims * rate / 100000 via reciprocal.
  // ---------------------------------------------------------------------------
  logic [DIV_FULL_W-1:0] recip_prod;
  logic [HOLD_Q_W-1:0]   hq_q;

  assign recip_prod = DIV_FULL_W'(hprod_q[HOLD_PROD_W-1:DIV_PRE_SHIFT])
                    * DIV_FULL_W'(DIV_RECIP);

  always_ff @(posedge clk_i) begin
    if (step_q == ST_DIV) begin
      hq_q <= recip_prod[DIV_FULL_W-1:DIV_SHIFT];
    end
  end

  // ---------------------------------------------------------------------------
  // ST_UPD: reload/decrement hold, slew or bypass, write the entry back.
  // ---------------------------------------------------------------------------
  logic [HOLD_BITS-1:0]   hold_sat, hold_new, wr_hold;
  logic                   rep;
  logic signed [SP_W-1:0] slew_adj;
  logic signed [SB:0]     slew_sum;
  logic signed [SB-1:0]   proc;

  assign hold_sat = (hq_q > HOLD_Q_W'(HOLD_MAX)) ? HOLD_BITS'(HOLD_MAX)
                                                 : HOLD_BITS'(hq_q);
  assign hold_new = click_q ? hold_sat : hold_old_q;
  assign rep      = (hold_new != '0);
  assign wr_hold  = rep ? hold_new - HOLD_BITS'(1) : hold_new;

  // floor((d * 0.1 + half) / 2^16)
  assign slew_adj = (slew_prod_q + SP_W'(32768)) >>> 16;
  assign slew_sum = (SB+1)'(slew_old_q) + (SB+1)'(slew_adj);
  assign proc     = rep ? SB'(slew_sum) : x_q;

  assign wr_data  = {x_q, proc, wr_hold};

  logic signed [SB:0] wdiff_q;
  logic               rep_q;

  always_ff @(posedge clk_i) begin
    if (step_q == ST_UPD) begin
      wdiff_q <= (SB+1)'(proc) - (SB+1)'(x_q);
      rep_q   <= rep;
    end
  end

  // ---------------------------------------------------------------------------
  // ST_MIX: x*(1-w) + p*w = x + (p-x)*w
  // ---------------------------------------------------------------------------
  logic signed [MP_W-1:0] mix_prod_q;

  always_ff @(posedge clk_i) begin
    if (step_q == ST_MIX) begin
      mix_prod_q <= MP_W'(wdiff_q) * MP_W'($signed({1'b0, wet_q}));
    end
  end

  // ---------------------------------------------------------------------------
  // ST_OUT: round, saturate, output register.
  // ---------------------------------------------------------------------------
  logic signed [MP_W-1:0] mix_sum, mix_shr;
  logic signed [SB-1:0]   mix_sat;

  assign mix_sum = (MP_W'(x_q) <<< 16) + mix_prod_q + MP_W'(32768);
  assign mix_shr = mix_sum >>> 16;
  assign mix_sat = (mix_shr > SAT_MAX) ? SB'(SAT_MAX)
                 : (mix_shr < SAT_MIN) ? SB'(SAT_MIN) : SB'(mix_shr);

  logic                 out_load;
  logic                 out_ch_q;
  logic signed [SB-1:0] out_sample_q;
  logic                 out_click_q;
  logic                 out_rep_q;

  assign out_load = (step_q == ST_OUT) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_ch_q     <= chbit_q;
      out_sample_q <= mix_sat;
      out_click_q  <= click_q;
      out_rep_q    <= rep_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign channel_out_o    = out_ch_q;
  assign sample_out_o     = out_sample_q;
  assign click_detected_o = out_click_q;
  assign repairing_o      = out_rep_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `CDSR_ASSERT_NEXT(a_accept_starts, in_valid_i && !in_stall_o, step_q == ST_DET, "accepted word did not start the sequence")
  `CDSR_ASSERT_NEXT(a_out_loaded, step_q == ST_OUT && out_free, out_valid_o && step_q == ST_IDLE, "result not loaded into free output register")
  `CDSR_ASSERT_NOW(a_hold_below_max, mem_we, wr_hold != HOLD_BITS'(HOLD_MAX), "hold counter written back without decrement")
  `CDSR_ASSERT_NOW(a_upd_after_div, step_q == ST_UPD, $past(step_q) == ST_DIV, "write-back reached without hold division")

endmodule

### tb/tb_click_detect_slew_repair_core.sv
// Self-checking testbench for the click detect / slew repair core with a scoreboard class.
`timescale 1ns / 100ps

module tb_click_detect_slew_repair_core import cdsr_pkg::*; ();

  localparam int SW          = DEF_SAMPLE_BITS;
  localparam int LOG_BITS    = DEF_LOG_TABLE_BITS;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE      = 8;      // idle margin after the pipe has emptied
  localparam int PHASES      = 11;
  localparam int RAND_WORDS  = 145;    // random words per register setting

  localparam longint FULL_MAX = (longint'(1) << (SW - 1)) - 1;
  localparam longint FULL_MIN = -FULL_MAX - 1;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 channel_i;
  logic signed [SW-1:0] sample_in_i;
  logic [THR_BITS-1:0]  threshold_cv_i;
  logic [15:0]          smoothing_cv_i;
  logic [WET_BITS-1:0]  amount_cv_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic                 channel_out_o;
  logic signed [SW-1:0] sample_out_o;
  logic                 click_detected_o;
  logic                 repairing_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  // One predicted output word.
  typedef struct {
    bit            channel;
    logic [SW-1:0] sample;
    bit            click;
    bit            repairing;
  } repair_word_t;

  // Predicts every output word from the accepted input words and the register
  // copies, and checks the words that come out against the predictions in order.
  class repair_scoreboard;
    logic [THR_BITS-1:0]  thr_reg;
    logic [CENT_BITS-1:0] cent_reg;
    logic [WET_BITS-1:0]  wet_reg;
    logic [RATE_BITS-1:0] rate_reg;
    logic [MOD_BITS-1:0]  mod_reg;
    longint               last_in [2];
    longint               slew_val [2];
    int unsigned          hold_left [2];
    repair_word_t         expected_q [$];
    int                   errors;
    int                   words_checked;
    int                   clicks_seen;
    int                   repairs_seen;

    function new();
      thr_reg  = THR_RESET;
      cent_reg = CENT_RESET;
      wet_reg  = WET_RESET;
      rate_reg = RATE_RESET;
      mod_reg  = MOD_RESET;
      for (int c = 0; c < 2; c++) begin
        last_in[c]   = 0;
        slew_val[c]  = 0;
        hold_left[c] = 0;
      end
      errors        = 0;
      words_checked = 0;
      clicks_seen   = 0;
      repairs_seen  = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_THRESHOLD: thr_reg  = data[THR_BITS-1:0];
        CFG_SMOOTHING: cent_reg = data[CENT_BITS-1:0];
        CFG_MIX:       wet_reg  = data[WET_BITS-1:0];
        CFG_RATE:      rate_reg = data[RATE_BITS-1:0];
        CFG_MOD_EN:    mod_reg  = data[MOD_BITS-1:0];
        default: ;     // unused indexes are dropped
      endcase
    endfunction

    // Hold time in centims from the top bits of the smoothing control:
    // 10 * 2^(log2(200) * k / (N - 1)) by integer part plus a cubic for the fraction.
    function longint unsigned log_hold_centims(longint unsigned k);
      longint unsigned span, e, f, p;
      int unsigned     ip;
      span = (longint'(1) << LOG_BITS) - 1;
      e    = (k * LOG2_200_Q16 + span / 2) / span;
      ip   = int'((e >> 16) & 15);
      f    = e & 64'hFFFF;
      p    = (EXP_C3 * f) >> 16;
      p    = ((p + EXP_C2) * f) >> 16;
      p    = ((p + EXP_C1) * f) >> 16;
      p    = p + 65536;
      return ((10 * p << ip) + 32768) >> 16;
    endfunction

    function void note_sample(bit ch, logic signed [SW-1:0] x_in, logic [15:0] tcv,
                              logic [15:0] scv, logic [15:0] acv);
      longint          x, d, delta, proc, mix, wet, thr, slew_k;
      longint unsigned cent, hold_n;
      repair_word_t    w;
      x      = longint'(x_in);
      slew_k = longint'(SLEW_COEF);
      thr    = mod_reg[MOD_THR_BIT] ?
               longint'(THR_MIN_Q16) + ((longint'(tcv) * longint'(THR_SPAN_Q16)) >>> 16) :
               longint'(thr_reg);
      cent   = mod_reg[MOD_CENT_BIT] ? log_hold_centims(64'(scv >> (16 - LOG_BITS))) :
               longint'(cent_reg);
      wet    = mod_reg[MOD_WET_BIT] ? longint'(acv) : longint'(wet_reg);

      delta = x - last_in[ch];
      if (delta < 0) delta = -delta;
      w.click = (delta << 16) > (thr << (SW - 1));
      if (w.click) begin
        hold_n = (cent * longint'(rate_reg)) / 100000;
        hold_left[ch] = (hold_n > HOLD_MAX) ? HOLD_MAX : int'(hold_n);
      end

      if (hold_left[ch] > 0) begin
        // one-pole slew toward the input, rounded, floor on negatives
        d = x - slew_val[ch];
        slew_val[ch] = slew_val[ch] + ((d * slew_k + 32768) >>> 16);
        proc = slew_val[ch];
        hold_left[ch]--;
        w.repairing = 1'b1;
      end else begin
        proc = x;
        slew_val[ch] = x;
        w.repairing = 1'b0;
      end

      mix = (x * (65536 - wet) + proc * wet + 32768) >>> 16;
      if (mix > FULL_MAX) mix = FULL_MAX;
      if (mix < FULL_MIN) mix = FULL_MIN;
      last_in[ch] = x;

      w.channel = ch;
      w.sample  = mix[SW-1:0];
      expected_q.insert(expected_q.size(), w);
    endfunction

    task report_mismatch(string what, longint got, longint want);
      $display("[%0t] mismatch, word %0d: %s got %0h expected %0h",
               $time, words_checked, what, got, want);
      errors++;
    endtask

    task check_word(bit ch, logic [SW-1:0] s, bit click, bit rep);
      repair_word_t w;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected word, sample", longint'(s), longint'(0));
      end else begin
        w = expected_q.pop_front();
        if (ch !== w.channel)
          report_mismatch("channel_out", longint'(ch), longint'(w.channel));
        if (s !== w.sample)
          report_mismatch("sample_out", longint'(s), longint'(w.sample));
        if (click !== w.click)
          report_mismatch("click_detected", longint'(click), longint'(w.click));
        if (rep !== w.repairing)
          report_mismatch("repairing", longint'(rep), longint'(w.repairing));
        clicks_seen  += int'(w.click);
        repairs_seen += int'(w.repairing);
      end
      words_checked++;
    endtask
  endclass

  repair_scoreboard sb = new();

  int     cycle_count = 0;
  int     gap_pct = 0;         // chance of an input gap before a word
  int     stall_pct = 0;       // chance of an output stall burst per cycle
  int     settings_run = 0;
  longint level [2];           // per-channel running signal for the random part

  click_detect_slew_repair_core DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .channel_i        (channel_i),
    .sample_in_i      (sample_in_i),
    .threshold_cv_i   (threshold_cv_i),
    .smoothing_cv_i   (smoothing_cv_i),
    .amount_cv_i      (amount_cv_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .channel_out_o    (channel_out_o),
    .sample_out_o     (sample_out_o),
    .click_detected_o (click_detected_o),
    .repairing_o      (repairing_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  // 10 ns clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Output side: take a word at every edge where valid is up and we are not stalling.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_word(channel_out_o, sample_out_o, click_detected_o, repairing_o);
  end

  // Output stall bursts of random length; the stall is released between bursts.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(1, 7)) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input bit ch, input logic signed [SW-1:0] x,
                           input logic [15:0] tcv, input logic [15:0] scv,
                           input logic [15:0] acv);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    channel_i      = ch;
    sample_in_i    = x;
    threshold_cv_i = tcv;
    smoothing_cv_i = scv;
    amount_cv_i    = acv;
    in_valid_i     = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_sample(ch, x, tcv, scv, acv);
    @(negedge clk_i);
  endtask

  // Let the pipe empty before touching the registers.
  task automatic drain_pipe();
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic load_settings(input int unsigned thr, input int unsigned cent,
                               input int unsigned wet, input int unsigned rate,
                               input int unsigned mod);
    write_reg(CFG_THRESHOLD, CFG_DATA_W'(thr));
    write_reg(CFG_SMOOTHING, CFG_DATA_W'(cent));
    write_reg(CFG_MIX, CFG_DATA_W'(wet));
    write_reg(CFG_RATE, CFG_DATA_W'(rate));
    write_reg(CFG_MOD_EN, CFG_DATA_W'(mod));
    // indexes past the last register must not disturb anything
    for (int u = int'(CFG_MOD_EN) + 1; u < (1 << CFG_IDX_W); u++)
      write_reg(u[CFG_IDX_W-1:0], CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1)));
    settings_run++;
  endtask

  function automatic logic [15:0] pick_cv();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'h0000;
    if (r < 20) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // Mostly a slowly moving signal per channel, with the odd jump, rail hit or repeat.
  task automatic send_random();
    bit                   ch;
    int                   r;
    longint               step;
    logic signed [SW-1:0] v;
    ch = 1'($urandom_range(0, 1));
    r  = $urandom_range(0, 99);
    if (r < 82) begin
      step = longint'($urandom_range(0, 1 << $urandom_range(2, 17)));
      if ($urandom_range(0, 1)) step = -step;
      level[ch] = level[ch] + step;
      if (level[ch] > FULL_MAX) level[ch] = FULL_MAX;
      if (level[ch] < FULL_MIN) level[ch] = FULL_MIN;
    end else if (r < 90) begin
      v = SW'($urandom);
      level[ch] = longint'(v);
    end else if (r < 94) begin
      level[ch] = $urandom_range(0, 1) ? FULL_MAX : FULL_MIN;
    end
    send_word(ch, level[ch][SW-1:0], pick_cv(), pick_cv(), pick_cv());
  endtask

  task automatic random_settings(input int unsigned mod);
    int unsigned thr, cent;
    thr  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, (1 << CFG_DATA_W) - 1) :
                                         $urandom_range(655, 65535);
    cent = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 2000) : $urandom_range(10, 300);
    load_settings(thr, cent, $urandom_range(0, 65535), $urandom_range(8000, 192000), mod);
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    channel_i      = 1'b0;
    sample_in_i    = '0;
    threshold_cv_i = '0;
    smoothing_cv_i = '0;
    amount_cv_i    = '0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_wdata_i    = '0;
    level[0]       = 0;
    level[1]       = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          // reset values; default threshold 6554 means a jump must exceed 838912
          gap_pct   = 25;
          stall_pct = 25;
          send_word(1'b0, 24'sd0, 16'h0000, 16'h0000, 16'h0000);          // no jump
          send_word(1'b0, 24'sh7FFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);     // full jump up
          send_word(1'b0, 24'sh7FFFFF, 16'h0000, 16'hFFFF, 16'h0000);     // hold continues
          send_word(1'b0, -24'sh800000, 16'hFFFF, 16'h0000, 16'hFFFF);    // rail to rail
          send_word(1'b1, -24'sh800000, 16'h0000, 16'h0000, 16'h0000);    // other channel
          send_word(1'b1, -24'sd8388600, 16'h0000, 16'h0000, 16'h0000);
          send_word(1'b1, -24'sd7549688, 16'h0000, 16'h0000, 16'h0000);   // at threshold
          send_word(1'b1, -24'sd6710775, 16'h0000, 16'h0000, 16'h0000);   // one past
          send_word(1'b0, -24'sd1, 16'h0000, 16'h0000, 16'h0000);
          send_word(1'b0, 24'sd0, 16'h0000, 16'h0000, 16'h0000);          // tiny step
        end
        1: begin
          // hold time rounds to no samples: click flagged, no slew; dry only
          drain_pipe();
          load_settings(655, 10, 0, 8000, 0);
          gap_pct   = 0;
          stall_pct = 0;
        end
        2: begin
          drain_pipe();
          load_settings(65535, 2000, 65535, 192000, 0);
          gap_pct   = 50;
          stall_pct = 10;
        end
        3: begin
          // zero threshold and a hold past the 12-bit counter
          drain_pipe();
          load_settings(0, 2047, 32768, (1 << RATE_BITS) - 1, 0);
          gap_pct   = 10;
          stall_pct = 50;
        end
        4: begin
          // every control taken from the word: sweep the control extremes
          drain_pipe();
          random_settings(7);
          gap_pct   = 25;
          stall_pct = 25;
          send_word(1'b0, 24'sh400000, 16'h0000, 16'h0000, 16'h0000);
          send_word(1'b0, -24'sh400000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
          send_word(1'b1, 24'sh7FFFFF, 16'h0000, 16'h00FF, 16'hFFFF);
          send_word(1'b1, 24'sd0, 16'hFFFF, 16'hFF00, 16'h0000);
          send_word(1'b0, 24'sh123456, 16'h8000, 16'h8000, 16'h8000);
          send_word(1'b1, -24'sh800000, 16'h0001, 16'h0100, 16'h0001);
        end
        PHASES - 1: begin
          // closing stretch, no gaps and no stalls
          drain_pipe();
          random_settings(5);
          gap_pct   = 0;
          stall_pct = 0;
        end
        default: begin
          drain_pipe();
          case (ph)
            5:       random_settings(1);
            6:       random_settings(2);
            7:       random_settings(4);
            8:       random_settings(3);
            9:       random_settings(6);
            default: random_settings($urandom_range(0, 7));
          endcase
          gap_pct   = $urandom_range(0, 60);
          stall_pct = $urandom_range(0, 60);
        end
      endcase
      repeat (RAND_WORDS) send_random();
    end

    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);

    $display("Checked %0d words under %0d register settings: %0d clicks, %0d repaired samples.",
             sb.words_checked, settings_run + 1, sb.clicks_seen, sb.repairs_seen);
    $display("Mismatches: %0d", sb.errors);
    if (sb.errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/cdsr_pkg.sv
rtl/click_detect_slew_repair_core.sv
tb/tb_click_detect_slew_repair_core.sv
